// ----- hw/rtl/reed_solomon_systematic_encoder_top_defines.svh -----
// ----------------------------------------------------------------------------
// Reed-Solomon encoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk, gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef REED_SOLOMON_SYSTEMATIC_ENCODER_TOP_DEFINES_SVH
`define REED_SOLOMON_SYSTEMATIC_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define RSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rse_pkg.sv -----
// ----------------------------------------------------------------------------
// Reed-Solomon encoder package
// Field constants, payload types and GF(256) arithmetic shared by the encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int MAX_PARITY = 32;
    localparam int CFG_W = 6;
    localparam int FIELD_MAX = 255;
    localparam logic [8:0] FIELD_POLY = 9'h11D;
    localparam logic [CFG_W-1:0] RESET_PARITY = CFG_W'(10);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    typedef logic [7:0] t_byte;
    typedef t_byte [MAX_PARITY-1:0] t_coeffs;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_parity;
        logic       last_of_block;
        logic       too_long;
    } t_out_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       too_long;
        logic       is_last;
    } t_msg_entry;

    typedef struct packed {
        logic             load;
        logic [CFG_W-1:0] count;
        logic             too_long;
    } t_par_load;

    function automatic t_byte gf_times2(input t_byte v);
        logic [8:0] t;
        t = {v, 1'b0};
        if (t[8]) begin
            t = t ^ FIELD_POLY;
        end
        return t[7:0];
    endfunction

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte x;
        acc = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = gf_times2(x);
        end
        return acc;
    endfunction

endpackage

// ----- hw/rtl/rse_gen.sv -----
// ----------------------------------------------------------------------------
// Reed-Solomon generator builder
// Holds the parity count and rebuilds g(x) one root per cycle after reset or a write.
// ----------------------------------------------------------------------------
module rse_gen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_write,
    input  logic [rse_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_busy,
    output logic [rse_pkg::CFG_W-1:0]    o_parity,
    output rse_pkg::t_coeffs             o_coeffs
);

    rse_pkg::t_byte [rse_pkg::MAX_PARITY:0] r_poly;
    rse_pkg::t_byte                         r_root;
    logic [rse_pkg::CFG_W-1:0]              r_iter;
    logic [rse_pkg::CFG_W-1:0]              r_parity;
    logic                                   r_busy;
    logic [rse_pkg::CFG_W-1:0]              n_parity;

    always_comb begin
        n_parity = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_parity = rse_pkg::CFG_W'(1);
        end else if (i_cfg_data > rse_pkg::CFG_W'(rse_pkg::MAX_PARITY)) begin
            n_parity = rse_pkg::CFG_W'(rse_pkg::MAX_PARITY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= rse_pkg::RESET_PARITY;
            r_busy   <= 1'b1;
            r_iter   <= '0;
            r_root   <= 8'd1;
            r_poly   <= '0;
            r_poly[0] <= 8'd1;
        end else if (i_cfg_write) begin
            r_parity <= n_parity;
            r_busy   <= 1'b1;
            r_iter   <= '0;
            r_root   <= 8'd1;
            r_poly   <= '0;
            r_poly[0] <= 8'd1;
        end else if (r_busy) begin
            for (int j = 1; j <= rse_pkg::MAX_PARITY; j++) begin
                r_poly[j] <= r_poly[j] ^ rse_pkg::gf_mul(r_poly[j-1], r_root);
            end
            r_root <= rse_pkg::gf_times2(r_root);
            r_iter <= r_iter + 1'b1;
            if (r_iter + 1'b1 == r_parity) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_parity = r_parity;
    assign o_coeffs = r_poly[rse_pkg::MAX_PARITY:1];

endmodule

// ----- hw/rtl/rse_front.sv -----
// ----------------------------------------------------------------------------
// Reed-Solomon encoder front end
// Runs the division register per message byte and tracks message length.
// ----------------------------------------------------------------------------
module rse_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  rse_pkg::t_in_item            i_item,
    input  logic                         i_cfg_write,
    input  logic [rse_pkg::CFG_W-1:0]    i_parity,
    input  rse_pkg::t_coeffs             i_coeffs,
    output rse_pkg::t_msg_entry          o_entry,
    output rse_pkg::t_par_load           o_par_load,
    output rse_pkg::t_coeffs             o_par_bytes
);

    rse_pkg::t_coeffs r_rem;
    logic [7:0]       r_count;
    logic             r_ovf;
    rse_pkg::t_coeffs n_rem;
    logic [7:0]       n_count;
    logic             n_ovf;
    rse_pkg::t_byte   fb;

    always_comb begin
        fb = i_item.data_byte ^ r_rem[0];
        for (int j = 0; j < rse_pkg::MAX_PARITY; j++) begin
            if (j + 1 < rse_pkg::MAX_PARITY) begin
                n_rem[j] = r_rem[j+1] ^ rse_pkg::gf_mul(i_coeffs[j], fb);
            end else begin
                n_rem[j] = rse_pkg::gf_mul(i_coeffs[j], fb);
            end
        end
        n_count = (r_count == 8'(rse_pkg::FIELD_MAX)) ? r_count : r_count + 1'b1;
        n_ovf   = r_ovf ||
                  (({1'b0, n_count} + 9'(i_parity)) > 9'(rse_pkg::FIELD_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_write) begin
            r_rem   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_item.is_last) begin
                r_rem   <= '0;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_rem   <= n_rem;
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
        end
    end

    assign o_entry.out_byte    = i_item.data_byte;
    assign o_entry.too_long    = n_ovf;
    assign o_entry.is_last     = i_item.is_last;
    assign o_par_load.load     = i_accept & i_item.is_last;
    assign o_par_load.count    = i_parity;
    assign o_par_load.too_long = n_ovf;
    assign o_par_bytes         = n_rem;

endmodule

// ----- hw/rtl/rse_fifo.sv -----
// ----------------------------------------------------------------------------
// Reed-Solomon encoder message queue
// Short queue of passed-through message bytes between front and back end.
// ----------------------------------------------------------------------------
module rse_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rse_pkg::t_msg_entry  i_entry,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output rse_pkg::t_msg_entry  o_head
);

    rse_pkg::t_msg_entry         r_mem [rse_pkg::FIFO_DEPTH];
    logic [rse_pkg::FIFO_AW-1:0] r_wr;
    logic [rse_pkg::FIFO_AW-1:0] r_rd;
    logic [rse_pkg::FIFO_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (rse_pkg::FIFO_AW+1)'(rse_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

endmodule

// ----- hw/rtl/rse_back.sv -----
// ----------------------------------------------------------------------------
// Reed-Solomon encoder back end
// Delivers queued message bytes, then unloads the parity snapshot after the last.
// ----------------------------------------------------------------------------
`include "reed_solomon_systematic_encoder_top_defines.svh"

module rse_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rse_pkg::t_msg_entry       i_head,
    input  logic                      i_fifo_empty,
    output logic                      o_fifo_pop,
    input  rse_pkg::t_par_load        i_load,
    input  rse_pkg::t_coeffs          i_bytes,
    input  logic                      i_pop,
    output logic                      o_empty,
    output rse_pkg::t_out_item        o_item,
    output logic                      o_snap_busy
);

    rse_pkg::t_coeffs            r_snap;
    logic [rse_pkg::CFG_W-1:0]   r_snap_cnt;
    logic                        r_snap_tl;
    logic                        r_snap_busy;
    logic                        r_par_active;
    logic [rse_pkg::CFG_W-1:0]   r_par_left;
    logic                        par_pop;

    assign o_fifo_pop = i_pop & !r_par_active & !i_fifo_empty;
    assign par_pop    = i_pop & r_par_active;
    assign o_empty    = !r_par_active & i_fifo_empty;

    always_comb begin
        if (r_par_active) begin
            o_item.out_byte      = r_snap[0];
            o_item.is_parity     = 1'b1;
            o_item.last_of_block = (r_par_left == rse_pkg::CFG_W'(1));
            o_item.too_long      = r_snap_tl;
        end else begin
            o_item.out_byte      = i_head.out_byte;
            o_item.is_parity     = 1'b0;
            o_item.last_of_block = 1'b0;
            o_item.too_long      = i_head.too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_snap     <= i_bytes;
            r_snap_cnt <= i_load.count;
            r_snap_tl  <= i_load.too_long;
        end else if (par_pop) begin
            r_snap <= r_snap >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_busy  <= 1'b0;
            r_par_active <= 1'b0;
            r_par_left   <= '0;
        end else begin
            if (i_load.load) begin
                r_snap_busy <= 1'b1;
            end
            if (o_fifo_pop && i_head.is_last) begin
                r_par_active <= 1'b1;
                r_par_left   <= r_snap_cnt;
            end
            if (par_pop) begin
                r_par_left <= r_par_left - 1'b1;
                if (r_par_left == rse_pkg::CFG_W'(1)) begin
                    r_par_active <= 1'b0;
                    r_snap_busy  <= 1'b0;
                end
            end
        end
    end

    assign o_snap_busy = r_snap_busy;

    `RSE_ASSERT_NOW(a_load_when_free, i_load.load, !r_snap_busy, "parity snapshot overwritten")
    `RSE_ASSERT_NOW(a_active_has_snap, r_par_active, r_snap_busy && r_par_left != '0, "parity unload without snapshot")
    `RSE_ASSERT_NEXT(a_final_parity_ends, par_pop && r_par_left == rse_pkg::CFG_W'(1), !r_par_active && !r_snap_busy, "parity unload did not end")

endmodule

// ----- hw/rtl/reed_solomon_systematic_encoder_top.sv -----
// ----------------------------------------------------------------------------
// Reed-Solomon systematic encoder, GF(256), field polynomial 0x11D
// Message bytes pass through one per cycle while full is low; the last one is
// followed by parity_count parity bytes, highest degree first.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while full is low; the division register
// is updated by one parallel GF multiply-accumulate over all parity
// bytes. After a byte marked is_last, the input shows full until that
// codeword's p parity bytes have been popped, since one parity snapshot
// register feeds the output. After reset, and after each parity_count write,
// the generator is rebuilt one root per cycle: full stays high and cfg ready
// low until the rebuild is done.
module reed_solomon_systematic_encoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  rse_pkg::t_in_item            i_in_item,
    output logic                         empty,
    input  logic                         pop,
    output rse_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rse_pkg::CFG_W-1:0]    i_cfg_data
);

    logic                        gen_busy;
    logic [rse_pkg::CFG_W-1:0]   parity;
    rse_pkg::t_coeffs            coeffs;
    logic                        cfg_write;
    logic                        accept;
    rse_pkg::t_msg_entry         entry;
    rse_pkg::t_par_load          par_load;
    rse_pkg::t_coeffs            par_bytes;
    logic                        fifo_full;
    logic                        fifo_empty;
    logic                        fifo_pop;
    rse_pkg::t_msg_entry         head;
    logic                        snap_busy;

    assign o_cfg_ready = !gen_busy;
    assign cfg_write   = i_cfg_valid & !gen_busy;
    assign full        = fifo_full | gen_busy | snap_busy;
    assign accept      = push & !full;

    rse_gen u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (cfg_write),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (gen_busy),
        .o_parity    (parity),
        .o_coeffs    (coeffs)
    );

    rse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_write (cfg_write),
        .i_parity    (parity),
        .i_coeffs    (coeffs),
        .o_entry     (entry),
        .o_par_load  (par_load),
        .o_par_bytes (par_bytes)
    );

    rse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (entry),
        .i_pop   (fifo_pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_head  (head)
    );

    rse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_fifo_empty (fifo_empty),
        .o_fifo_pop   (fifo_pop),
        .i_load       (par_load),
        .i_bytes      (par_bytes),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_item       (o_out_item),
        .o_snap_busy  (snap_busy)
    );

endmodule

// ----- bench/reed_solomon_systematic_encoder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reed-Solomon systematic encoder testbench
// Streams messages through the encoder under random push/pop gaps and parity
// count changes. A scoreboard keeps its own GF(256) division register and
// compares every popped byte with the predicted codeword byte.
// ----------------------------------------------------------------------------

class rs_codeword_tracker;

    int unsigned mismatches;
    rse_pkg::t_out_item expected_bytes[$];
    bit [5:0] parity_count;
    bit [7:0] generator[rse_pkg::MAX_PARITY];
    bit [7:0] remainder[rse_pkg::MAX_PARITY];
    int unsigned bytes_seen;
    bit too_long_seen;
    bit [7:0] antilog[255];
    int unsigned logof[256];

    function new();
        bit [8:0] v;
        mismatches = 0;
        v = 9'd1;
        for (int i = 0; i < 255; i++) begin
            antilog[i] = v[7:0];
            logof[v[7:0]] = i;
            v = {v[7:0], 1'b0};
            if (v[8]) begin
                v = v ^ rse_pkg::FIELD_POLY;
            end
        end
        parity_count = rse_pkg::RESET_PARITY;
        rebuild_generator();
        restart_message();
    endfunction

    function bit [7:0] field_product(bit [7:0] a, bit [7:0] b);
        if (a == 8'h00 || b == 8'h00) begin
            return 8'h00;
        end
        return antilog[(logof[a] + logof[b]) % 255];
    endfunction

    function void rebuild_generator();
        bit [7:0] poly[rse_pkg::MAX_PARITY + 1];
        bit [7:0] root;
        foreach (poly[j]) begin
            poly[j] = 8'h00;
        end
        poly[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < int'(parity_count); i++) begin
            for (int j = int'(parity_count); j > 0; j--) begin
                poly[j] = poly[j] ^ field_product(poly[j-1], root);
            end
            root = field_product(root, 8'h02);
        end
        foreach (generator[j]) begin
            generator[j] = (j < int'(parity_count)) ? poly[j+1] : 8'h00;
        end
    endfunction

    function void restart_message();
        foreach (remainder[j]) begin
            remainder[j] = 8'h00;
        end
        bytes_seen = 0;
        too_long_seen = 1'b0;
    endfunction

    function void load_parity_count(bit [5:0] value);
        bit [5:0] v;
        v = value;
        if (v == 6'd0) begin
            v = 6'd1;
        end
        if (int'(v) > rse_pkg::MAX_PARITY) begin
            v = 6'(rse_pkg::MAX_PARITY);
        end
        parity_count = v;
        rebuild_generator();
        restart_message();
    endfunction

    function void add_expected(rse_pkg::t_out_item want);
        expected_bytes.insert(expected_bytes.size(), want);
    endfunction

    function void note_message_byte(rse_pkg::t_in_item item);
        rse_pkg::t_out_item want;
        bit [7:0] fb;
        int p;
        p = int'(parity_count);
        if (bytes_seen < rse_pkg::FIELD_MAX) begin
            bytes_seen++;
        end
        if (int'(bytes_seen) > rse_pkg::FIELD_MAX - p) begin
            too_long_seen = 1'b1;
        end
        fb = item.data_byte ^ remainder[0];
        for (int j = 0; j + 1 < p; j++) begin
            remainder[j] = remainder[j+1] ^ field_product(generator[j], fb);
        end
        remainder[p-1] = field_product(generator[p-1], fb);
        want.out_byte = item.data_byte;
        want.is_parity = 1'b0;
        want.last_of_block = 1'b0;
        want.too_long = too_long_seen;
        add_expected(want);
        if (item.is_last) begin
            for (int j = 0; j < p; j++) begin
                want.out_byte = remainder[j];
                want.is_parity = 1'b1;
                want.last_of_block = (j == p - 1);
                want.too_long = too_long_seen;
                add_expected(want);
            end
            restart_message();
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    task report_mismatch(string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task check_codeword_byte(rse_pkg::t_out_item got);
        rse_pkg::t_out_item want;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %02h popped with nothing pending", got.out_byte));
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      got.out_byte, want.out_byte));
        end
        if (got.is_parity !== want.is_parity) begin
            report_mismatch($sformatf("is_parity got %b want %b",
                                      got.is_parity, want.is_parity));
        end
        if (got.last_of_block !== want.last_of_block) begin
            report_mismatch($sformatf("last_of_block got %b want %b",
                                      got.last_of_block, want.last_of_block));
        end
        if (got.too_long !== want.too_long) begin
            report_mismatch($sformatf("too_long got %b want %b",
                                      got.too_long, want.too_long));
        end
    endtask

endclass

module reed_solomon_systematic_encoder_top_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int CFG_SETTLE = 4;
    localparam int END_SETTLE = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    rse_pkg::t_in_item i_in_item = '0;
    logic empty;
    logic pop = 1'b0;
    rse_pkg::t_out_item o_out_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [rse_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic hold_pop_req = 1'b0;

    rs_codeword_tracker tracker;

    reed_solomon_systematic_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                tracker.note_message_byte(i_in_item);
            end
            if (pop && !empty) begin
                tracker.check_codeword_byte(o_out_item);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.load_parity_count(i_cfg_data);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("reed_solomon_systematic_encoder_top_tb failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [5:0] pick_parity();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                return 6'd0;
            end
            1: begin
                return 6'd1;
            end
            2: begin
                return 6'd32;
            end
            3: begin
                return 6'd63;
            end
            4: begin
                return 6'd33;
            end
            default: begin
                return 6'($urandom_range(2, 31));
            end
        endcase
    endfunction

    function automatic int pick_length();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(7, 20);
        end
        return $urandom_range(1, 6);
    endfunction

    initial begin : result_sink
        int gap_left;
        int burst_left;
        bit hold_done;
        gap_left = 0;
        burst_left = 0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_pop_req && !hold_done) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
                pop = 1'b1;
            end else if (burst_left > 0) begin
                pop = 1'b1;
                burst_left--;
            end else if (gap_left > 0) begin
                pop = 1'b0;
                gap_left--;
            end else begin
                pop = 1'b1;
                if ($urandom_range(0, 99) < 8) begin
                    burst_left = $urandom_range(40, 160);
                end else begin
                    gap_left = pick_gap();
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last_flag, input int gap);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_in_item.data_byte = value;
        i_in_item.is_last = last_flag;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit with_gaps);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), i == len - 1, with_gaps ? pick_gap() : 0);
        end
    endtask

    task automatic drain_codewords();
        push = 1'b0;
        while (tracker.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_parity_count(input logic [5:0] value);
        drain_codewords();
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : stimulus
        int len;
        int sent;
        tracker = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_byte(8'h00, 1'b0, 0);
        send_byte(8'hFF, 1'b0, 0);
        send_byte(8'h01, 1'b0, 0);
        send_byte(8'h80, 1'b1, 0);
        send_byte(8'hFF, 1'b1, 0);
        write_parity_count(6'd0);
        send_byte(8'hA5, 1'b1, 0);
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'hFF, 1'b1, 0);
        write_parity_count(6'd63);
        send_byte(8'h12, 1'b0, 0);
        send_byte(8'hFF, 1'b1, 0);
        write_parity_count(6'd33);
        send_byte(8'h7E, 1'b1, 0);
        write_parity_count(6'd1);
        send_byte(8'h55, 1'b0, 0);
        send_byte(8'hAA, 1'b0, 0);
        // drop the partial message
        write_parity_count(6'd5);
        send_byte(8'h3C, 1'b0, 0);
        send_byte(8'hC3, 1'b1, 0);
        write_parity_count(6'd32);
        send_byte(8'hFF, 1'b1, 2);

        len = rse_pkg::FIELD_MAX - rse_pkg::MAX_PARITY + $urandom_range(1, 8);
        send_message(len, 1'b1);
        send_message($urandom_range(1, 6), 1'b1);

        for (int phase = 0; phase < 8; phase++) begin
            write_parity_count(pick_parity());
            if (phase == 3) begin
                hold_pop_req = 1'b1;
            end
            if (phase == 6) begin
                send_message(pick_length(), 1'b1);
                drain_codewords();
            end
            sent = 0;
            while (sent < 6) begin
                len = pick_length();
                send_message(len, phase != 3);
                sent += len;
            end
        end

        drain_codewords();
        repeat (END_SETTLE) @(negedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("reed_solomon_systematic_encoder_top_tb passed");
        end else begin
            $display("reed_solomon_systematic_encoder_top_tb failed");
        end
        $finish;
    end

endmodule

// ----- reed_solomon_systematic_encoder_top.f -----
+incdir+hw/rtl
hw/rtl/rse_pkg.sv
hw/rtl/rse_gen.sv
hw/rtl/rse_front.sv
hw/rtl/rse_fifo.sv
hw/rtl/rse_back.sv
hw/rtl/reed_solomon_systematic_encoder_top.sv
bench/reed_solomon_systematic_encoder_top_tb.sv
